// ===== hw/rtl/ant_sfr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ANT serial frame receiver.
// Holds the parser phase type, protocol constants and default sizes; no dependencies.
package ant_sfr_pkg;

  localparam int DEF_MAX_PAYLOAD = 16;
  localparam int CHAN_CNT_W      = 4;
  localparam logic [CHAN_CNT_W-1:0] CHAN_CNT_RESET = 4'd8;

  localparam int OUT_TDATA_W = 32;

  localparam logic [7:0] SYNC_BYTE         = 8'hA4;
  localparam logic [7:0] ID_CHANNEL_EVENT  = 8'h40;
  localparam logic [7:0] ID_BROADCAST      = 8'h4E;
  localparam logic [7:0] ID_ACKNOWLEDGED   = 8'h4F;
  localparam logic [7:0] ID_BURST          = 8'h50;
  localparam logic [7:0] ID_CHANNEL_ID     = 8'h51;
  localparam logic [7:0] ID_CHANNEL_STATUS = 8'h52;
  localparam logic [7:0] CODE_TX_FAILED    = 8'h06;
  localparam logic [2:0] CHAN_MASK         = 3'h7;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LENGTH = 3'd1,
    PH_ID     = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4,
    PH_REPLAY = 3'd5
  } phase_t;

endpackage

// ===== hw/rtl/ant_sfr_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used for the payload buffer of the frame receiver.
module ant_sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/ant_serial_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// Top level of the ANT serial frame receiver: byte parser, checksum and payload replay.
// Depends on ant_sfr_pkg and ant_sfr_ram.
//
// The block takes one serial byte per item and hunts for ANT frames (sync, length, id,
// payload, XOR checksum). Header and payload bytes are accepted one per cycle; payload
// bytes go into a small RAM that is not cleared after reset. When the checksum byte
// matches, the input stalls while the payload is read back from the RAM's single read
// port, one entry per cycle unless the output stalls, so a good frame holds the input
// until its last payload byte is loaded for output. Frames with a bad checksum or a bad
// length give no items. The channel count register is written on the cfg port.
module ant_serial_frame_receiver_core #(
  parameter int MAX_PAYLOAD = ant_sfr_pkg::DEF_MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst_n,
  // Fields: rx_byte[7:0].
  input  logic [7:0]  in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields: message_id[7:0], chan_num[10:8], payload_index[14:11],
  // payload_byte[22:15], frame_length[27:23], zero fill above.
  output logic [ant_sfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Fields: route_to_channel[0].
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [ant_sfr_pkg::CHAN_CNT_W-1:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  ant_sfr_pkg::phase_t phase_r, phase_nxt;

  logic [ant_sfr_pkg::CHAN_CNT_W-1:0] chan_cnt_r;
  logic [7:0]       xor_r, xor_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [2:0]       chan_r, chan_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             route_r, route_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] pend_idx_r, pend_idx_nxt;

  logic [7:0]       o_id_r, o_byte_r;
  logic [2:0]       o_chan_r;
  logic [3:0]       o_idx_r;
  logic [4:0]       o_len_r;
  logic             o_route_r, o_last_r, o_valid_r;

  logic             in_acc, load, rd_issue, wr_en, route_kind, len_bad;
  logic [7:0]       rd_data, code_eff;
  logic [31:0]      len_ext, idx_ext;

  assign cfg_ready = 1'b1;
  assign in_tready = (phase_r != ant_sfr_pkg::PH_REPLAY);
  assign in_acc    = in_tvalid && in_tready;
  assign load      = pend_r && (!o_valid_r || out_tready);
  assign rd_issue  = (phase_r == ant_sfr_pkg::PH_REPLAY) && (rd_cnt_r < len_r)
                     && (!pend_r || load);
  assign wr_en     = in_acc && (phase_r == ant_sfr_pkg::PH_DATA)
                     && (32'(cnt_r) < MAX_PAYLOAD);
  assign len_bad   = (in_tdata == 8'd0) || (in_tdata > 8'(MAX_PAYLOAD));
  assign code_eff  = (32'(len_r) > 32'd2) ? code_r : 8'd0;
  assign len_ext   = 32'(len_r);
  assign idx_ext   = 32'(pend_idx_r);

  always_comb begin
    unique case (id_r)
      ant_sfr_pkg::ID_BROADCAST, ant_sfr_pkg::ID_ACKNOWLEDGED, ant_sfr_pkg::ID_BURST,
      ant_sfr_pkg::ID_CHANNEL_ID, ant_sfr_pkg::ID_CHANNEL_STATUS: route_kind = 1'b1;
      ant_sfr_pkg::ID_CHANNEL_EVENT: route_kind = (code_eff != ant_sfr_pkg::CODE_TX_FAILED);
      default: route_kind = 1'b0;
    endcase
  end

  ant_sfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_en   (rd_issue),
    .rd_addr (rd_cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      ant_sfr_pkg::PH_LENGTH: begin
        if (in_acc) begin
          phase_nxt = len_bad ? ant_sfr_pkg::PH_HUNT : ant_sfr_pkg::PH_ID;
        end
      end
      ant_sfr_pkg::PH_ID: begin
        if (in_acc) begin
          phase_nxt = ant_sfr_pkg::PH_DATA;
        end
      end
      ant_sfr_pkg::PH_DATA: begin
        if (in_acc && ((cnt_r + CNT_W'(1)) >= len_r)) begin
          phase_nxt = ant_sfr_pkg::PH_CHECK;
        end
      end
      ant_sfr_pkg::PH_CHECK: begin
        if (in_acc) begin
          phase_nxt = (xor_r == in_tdata) ? ant_sfr_pkg::PH_REPLAY : ant_sfr_pkg::PH_HUNT;
        end
      end
      ant_sfr_pkg::PH_REPLAY: begin
        if ((rd_cnt_r >= len_r) && (!pend_r || load)) begin
          phase_nxt = ant_sfr_pkg::PH_HUNT;
        end
      end
      default: begin
        if (in_acc) begin
          phase_nxt = (in_tdata == ant_sfr_pkg::SYNC_BYTE) ? ant_sfr_pkg::PH_LENGTH
                                                           : ant_sfr_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    xor_nxt      = xor_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    id_nxt       = id_r;
    chan_nxt     = chan_r;
    code_nxt     = code_r;
    route_nxt    = route_r;
    rd_cnt_nxt   = rd_issue ? (rd_cnt_r + CNT_W'(1)) : rd_cnt_r;
    pend_nxt     = rd_issue ? 1'b1 : (load ? 1'b0 : pend_r);
    pend_idx_nxt = rd_issue ? rd_cnt_r : pend_idx_r;
    if (in_acc) begin
      unique case (phase_r)
        ant_sfr_pkg::PH_LENGTH: begin
          if (!len_bad) begin
            xor_nxt = xor_r ^ in_tdata;
            len_nxt = in_tdata[CNT_W-1:0];
            cnt_nxt = '0;
          end
        end
        ant_sfr_pkg::PH_ID: begin
          id_nxt  = in_tdata;
          xor_nxt = xor_r ^ in_tdata;
        end
        ant_sfr_pkg::PH_DATA: begin
          xor_nxt = xor_r ^ in_tdata;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == '0) begin
            chan_nxt = in_tdata[2:0] & ant_sfr_pkg::CHAN_MASK;
          end
          if (32'(cnt_r) == 32'd2) begin
            code_nxt = in_tdata;
          end
        end
        ant_sfr_pkg::PH_CHECK: begin
          route_nxt  = route_kind && ({1'b0, chan_r} < chan_cnt_r);
          rd_cnt_nxt = '0;
          pend_nxt   = 1'b0;
        end
        ant_sfr_pkg::PH_REPLAY: begin
        end
        default: begin
          if (in_tdata == ant_sfr_pkg::SYNC_BYTE) begin
            xor_nxt = ant_sfr_pkg::SYNC_BYTE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ant_sfr_pkg::PH_HUNT;
      chan_cnt_r <= ant_sfr_pkg::CHAN_CNT_RESET;
      xor_r      <= ant_sfr_pkg::SYNC_BYTE;
      len_r      <= '0;
      cnt_r      <= '0;
      id_r       <= '0;
      rd_cnt_r   <= '0;
      pend_r     <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      xor_r     <= xor_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      id_r      <= id_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      pend_r    <= pend_nxt;
      o_valid_r <= load ? 1'b1 : (out_tready ? 1'b0 : o_valid_r);
      if (cfg_valid && cfg_ready) begin
        chan_cnt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chan_r     <= chan_nxt;
    code_r     <= code_nxt;
    route_r    <= route_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (load) begin
      o_id_r    <= id_r;
      o_chan_r  <= chan_r;
      o_route_r <= route_r;
      o_idx_r   <= idx_ext[3:0];
      o_byte_r  <= rd_data;
      o_len_r   <= len_ext[4:0];
      o_last_r  <= (pend_idx_r + CNT_W'(1)) == len_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tuser  = o_route_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {4'd0, o_len_r, o_byte_r, o_idx_r, o_chan_r, o_id_r};

`ifndef SYNTHESIS
  a_no_input_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_tready)
    else $error("input accepted while payload replay is pending");

  a_bad_check_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (phase_r == ant_sfr_pkg::PH_CHECK) && (in_tdata != xor_r))
      |=> (phase_r == ant_sfr_pkg::PH_HUNT))
    else $error("checksum mismatch did not return to hunting");

  a_data_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ant_sfr_pkg::PH_DATA) |-> ((len_r != '0) && (cnt_r < len_r)))
    else $error("payload count out of range");
`endif

endmodule

// ===== tb/sv/ant_serial_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the ANT serial frame receiver core: drives bytes, predicts frames.
// Depends on ant_sfr_pkg and ant_serial_frame_receiver_core; no files or arguments.
module ant_serial_frame_receiver_core_tb;

  localparam int RANDOM_ITEMS = 50;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE       = 16;
  localparam int IDLE_LIMIT   = 1000;
  localparam int CODE_POS     = 2;
  localparam logic [7:0] ROUTED_IDS [6] = '{ant_sfr_pkg::ID_BROADCAST,
                                           ant_sfr_pkg::ID_ACKNOWLEDGED,
                                           ant_sfr_pkg::ID_BURST,
                                           ant_sfr_pkg::ID_CHANNEL_ID,
                                           ant_sfr_pkg::ID_CHANNEL_STATUS,
                                           ant_sfr_pkg::ID_CHANNEL_EVENT};

  typedef logic [7:0] payload_t [ant_sfr_pkg::DEF_MAX_PAYLOAD];

  typedef struct {
    logic [7:0] msg_id;
    logic [2:0] chan;
    logic       route;
    logic [3:0] index;
    logic [7:0] data;
    logic [4:0] length;
    logic       last;
  } frame_byte_t;

  logic clk;
  logic rst_n;
  logic [7:0] in_tdata;
  logic in_tvalid;
  logic in_tready;
  logic [ant_sfr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [ant_sfr_pkg::CHAN_CNT_W-1:0] cfg_data;
  logic cfg_valid;
  logic cfg_ready;

  ant_serial_frame_receiver_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data(cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predicted parser state.
  ant_sfr_pkg::phase_t pred_phase;
  logic [7:0] pred_xor;
  logic [4:0] pred_length;
  logic [4:0] pred_count;
  logic [7:0] pred_msg_id;
  logic [7:0] pred_store [ant_sfr_pkg::DEF_MAX_PAYLOAD];
  logic [ant_sfr_pkg::CHAN_CNT_W-1:0] pred_chan_count;

  frame_byte_t pending_bytes [$];
  int fail_count;
  int frame_bytes_sent;
  int good_frames;
  int bytes_checked;
  int count_settings;
  int idle_cycles;
  bit src_gaps;
  bit sink_gaps;
  bit hold_request;

  function automatic void predict_reset();
    pred_phase = ant_sfr_pkg::PH_HUNT;
    pred_xor = ant_sfr_pkg::SYNC_BYTE;
    pred_length = '0;
    pred_count = '0;
    pred_msg_id = '0;
    pred_chan_count = ant_sfr_pkg::CHAN_CNT_RESET;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    frame_byte_t r;
    logic [2:0] chan;
    bit kind_ok;
    if (pred_phase != ant_sfr_pkg::PH_HUNT || b == ant_sfr_pkg::SYNC_BYTE) frame_bytes_sent++;
    case (pred_phase)
      ant_sfr_pkg::PH_LENGTH: begin
        if (b == 8'd0 || b > ant_sfr_pkg::DEF_MAX_PAYLOAD) begin
          pred_phase = ant_sfr_pkg::PH_HUNT;
        end else begin
          pred_xor ^= b;
          pred_length = b[4:0];
          pred_count = '0;
          pred_phase = ant_sfr_pkg::PH_ID;
        end
      end
      ant_sfr_pkg::PH_ID: begin
        pred_msg_id = b;
        pred_xor ^= b;
        pred_phase = ant_sfr_pkg::PH_DATA;
      end
      ant_sfr_pkg::PH_DATA: begin
        if (pred_count < ant_sfr_pkg::DEF_MAX_PAYLOAD) pred_store[pred_count] = b;
        pred_xor ^= b;
        pred_count++;
        if (pred_count >= pred_length) pred_phase = ant_sfr_pkg::PH_CHECK;
      end
      ant_sfr_pkg::PH_CHECK: begin
        if (pred_xor == b) begin
          chan = pred_store[0][2:0] & ant_sfr_pkg::CHAN_MASK;
          case (pred_msg_id)
            ant_sfr_pkg::ID_BROADCAST, ant_sfr_pkg::ID_ACKNOWLEDGED, ant_sfr_pkg::ID_BURST,
            ant_sfr_pkg::ID_CHANNEL_ID, ant_sfr_pkg::ID_CHANNEL_STATUS: begin
              kind_ok = 1'b1;
            end
            ant_sfr_pkg::ID_CHANNEL_EVENT: begin
              kind_ok = (pred_length > CODE_POS)
                        ? (pred_store[CODE_POS] != ant_sfr_pkg::CODE_TX_FAILED) : 1'b1;
            end
            default: begin
              kind_ok = 1'b0;
            end
          endcase
          good_frames++;
          for (int k = 0; k < pred_length; k++) begin
            r.msg_id = pred_msg_id;
            r.chan = chan;
            r.route = kind_ok && ({1'b0, chan} < pred_chan_count);
            r.index = k[3:0];
            r.data = pred_store[k];
            r.length = pred_length;
            r.last = (k + 1 == pred_length);
            pending_bytes.push_back(r);
          end
        end
        pred_phase = ant_sfr_pkg::PH_HUNT;
      end
      default: begin
        if (b == ant_sfr_pkg::SYNC_BYTE) begin
          pred_phase = ant_sfr_pkg::PH_LENGTH;
          pred_xor = ant_sfr_pkg::SYNC_BYTE;
        end else begin
          pred_phase = ant_sfr_pkg::PH_HUNT;
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == ant_sfr_pkg::SYNC_BYTE) b = 8'h00;
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    deframe_byte(b);
  endtask

  task automatic send_frame(input int len, input logic [7:0] id, input payload_t pl,
                            input bit corrupt);
    logic [7:0] sum;
    sum = ant_sfr_pkg::SYNC_BYTE ^ 8'(len) ^ id;
    send_byte(ant_sfr_pkg::SYNC_BYTE);
    send_byte(8'(len));
    send_byte(id);
    for (int k = 0; k < len; k++) begin
      send_byte(pl[k]);
      sum ^= pl[k];
    end
    send_byte(corrupt ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum);
  endtask

  task automatic send_short(input logic [7:0] id, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input int len);
    payload_t pl;
    pl = '{default: 8'h00};
    pl[0] = b0;
    pl[1] = b1;
    pl[2] = b2;
    send_frame(len, id, pl, 1'b0);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic write_channel_count(input logic [ant_sfr_pkg::CHAN_CNT_W-1:0] value);
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    pred_chan_count = value;
    count_settings++;
  endtask

  task automatic random_frame();
    payload_t pl;
    int len;
    int pick;
    logic [7:0] id;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
    id = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                     : ROUTED_IDS[$urandom_range(0, 5)];
    foreach (pl[k]) pl[k] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) pl[CODE_POS] = ant_sfr_pkg::CODE_TX_FAILED;
    if ($urandom_range(0, 15) == 0) pl[$urandom_range(0, len - 1)] = ant_sfr_pkg::SYNC_BYTE;
    if (pick < 72) begin
      send_frame(len, id, pl, 1'b0);
    end else if (pick < 80) begin
      send_frame(len, id, pl, 1'b1);
    end else if (pick < 86) begin
      send_byte(ant_sfr_pkg::SYNC_BYTE);
      send_byte((pick < 83) ? 8'h00
                            : 8'($urandom_range(ant_sfr_pkg::DEF_MAX_PAYLOAD + 1, 255)));
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 4)) send_byte(noise_byte());
    end else begin
      // The frame breaks off; the next frame's bytes are absorbed as its tail.
      send_byte(ant_sfr_pkg::SYNC_BYTE);
      send_byte(8'(len));
      send_byte(id);
      for (int k = 0; k < len / 2; k++) send_byte(pl[k]);
    end
  endtask

  task automatic test_header_errors();
    payload_t pl;
    pl = '{default: 8'h00};
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ant_sfr_pkg::SYNC_BYTE);
    send_byte(8'h00);
    send_byte(ant_sfr_pkg::SYNC_BYTE);
    send_byte(8'(ant_sfr_pkg::DEF_MAX_PAYLOAD + 1));
    send_byte(ant_sfr_pkg::SYNC_BYTE);
    send_byte(ant_sfr_pkg::SYNC_BYTE);
    send_frame(1, ant_sfr_pkg::ID_BROADCAST, pl, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_message_kinds();
    payload_t pl;
    foreach (ROUTED_IDS[i]) send_short(ROUTED_IDS[i], 8'(i), 8'h5A, 8'h01, 2);
    send_short(ant_sfr_pkg::ID_CHANNEL_EVENT, 8'h07, 8'h01, ant_sfr_pkg::CODE_TX_FAILED, 3);
    send_short(ant_sfr_pkg::ID_CHANNEL_EVENT, 8'h02, 8'h01, 8'h03, 3);
    send_short(ant_sfr_pkg::ID_CHANNEL_EVENT, 8'h03, ant_sfr_pkg::CODE_TX_FAILED,
               ant_sfr_pkg::CODE_TX_FAILED, 1);
    send_short(ant_sfr_pkg::ID_CHANNEL_EVENT, 8'h04, ant_sfr_pkg::CODE_TX_FAILED,
               ant_sfr_pkg::CODE_TX_FAILED, 2);
    send_short(8'h00, 8'h01, 8'h00, 8'h00, 1);
    send_short(8'hFF, 8'hFE, 8'h00, 8'h00, 1);
    send_short(ant_sfr_pkg::ID_BURST, 8'h01, ant_sfr_pkg::SYNC_BYTE,
               ant_sfr_pkg::SYNC_BYTE, 3);
    pl = '{default: 8'hFF};
    send_frame(ant_sfr_pkg::DEF_MAX_PAYLOAD, ant_sfr_pkg::ID_BROADCAST, pl, 1'b0);
    send_frame(4, ant_sfr_pkg::ID_BROADCAST, pl, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_channel_count();
    logic [ant_sfr_pkg::CHAN_CNT_W-1:0] counts [4];
    counts = '{4'd0, 4'd3, 4'd5, 4'd8};
    foreach (counts[i]) begin
      write_channel_count(counts[i]);
      for (int c = 0; c < 8; c += 3) begin
        send_short(ant_sfr_pkg::ID_BROADCAST, 8'($urandom_range(0, 31) * 8 + c),
                   8'h00, 8'h00, 1);
      end
    end
    wait_results_drained();
  endtask

  task automatic test_output_holdoff();
    payload_t pl;
    foreach (pl[k]) pl[k] = 8'($urandom_range(0, 255));
    src_gaps = 1'b0;
    hold_request = 1'b1;
    repeat (2) send_frame(8, ant_sfr_pkg::ID_ACKNOWLEDGED, pl, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int frames;
    int target;
    frames = 0;
    target = frame_bytes_sent + RANDOM_ITEMS;
    while (frame_bytes_sent < target) begin
      if (frames % 12 == 0) begin
        src_gaps = $urandom_range(0, 1);
        sink_gaps = $urandom_range(0, 1);
      end
      if (frames % 6 == 5 && pred_phase == ant_sfr_pkg::PH_HUNT) begin
        write_channel_count(4'($urandom_range(0, 8)));
      end
      random_frame();
      frames++;
    end
    wait_results_drained();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        $error("Result item arrived with none predicted: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        check_field("message_id", want.msg_id, out_tdata[7:0]);
        check_field("chan_num", want.chan, out_tdata[10:8]);
        check_field("payload_index", want.index, out_tdata[14:11]);
        check_field("payload_byte", want.data, out_tdata[22:15]);
        check_field("frame_length", want.length, out_tdata[27:23]);
        check_field("tdata_fill", 0, out_tdata[ant_sfr_pkg::OUT_TDATA_W-1:28]);
        check_field("route_to_channel", want.route, out_tuser);
        check_field("last_byte", want.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("No item moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = sink_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin
    fail_count = 0;
    frame_bytes_sent = 0;
    good_frames = 0;
    bytes_checked = 0;
    count_settings = 0;
    idle_cycles = 0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    hold_request = 1'b0;
    predict_reset();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_errors();
    test_message_kinds();
    test_channel_count();
    test_output_holdoff();
    test_random_traffic();

    wait_results_drained();
    repeat (32) @(posedge clk);
    $display("Sent %0d frame bytes; %0d good frames gave %0d checked payload items.",
             frame_bytes_sent, good_frames, bytes_checked);
    $display("Channel count written %0d times, with idle gaps and a long output hold-off.",
             count_settings);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
